@@ sv/rclbs_pkg.sv @@
// ----------------------------------------------------------------------------
// rclbs_pkg
// Types and constants shared by the bind and data sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package rclbs_pkg;

  localparam int HOP_COUNT        = 5;
  localparam int BIND_RETRY_LIMIT = 50;
  localparam int CONFIG_REPEATS   = 10;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_START_DATA = 2'd1;
  localparam logic [1:0] CMD_START_BIND = 2'd2;
  localparam logic [1:0] CMD_OPTIONS    = 2'd3;

  localparam logic [3:0] ACT_IDLE       = 4'd0;
  localparam logic [3:0] ACT_SEND_BIND  = 4'd1;
  localparam logic [3:0] ACT_TO_RX      = 4'd2;
  localparam logic [3:0] ACT_BIND_OK    = 4'd3;
  localparam logic [3:0] ACT_SEND_DATA  = 4'd4;
  localparam logic [3:0] ACT_SEND_RXCFG = 4'd5;
  localparam logic [3:0] ACT_SEND_FS    = 4'd6;
  localparam logic [3:0] ACT_START_BIND = 4'd7;
  localparam logic [3:0] ACT_START_DATA = 4'd8;

  localparam logic [14:0] DLY_NONE   = 15'd0;
  localparam logic [14:0] DLY_SHORT  = 15'd1;
  localparam logic [14:0] DLY_START  = 15'd500;
  localparam logic [14:0] DLY_LISTEN = 15'd1000;
  localparam logic [14:0] DLY_SEND   = 15'd2000;
  localparam logic [14:0] DLY_DATA   = 15'd18000;
  localparam logic [14:0] DLY_CONFIG = 15'd20000;

  localparam logic [7:0] BYTE_O = 8'h4F;
  localparam logic [7:0] BYTE_K = 8'h4B;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        rx_ready;
    logic [7:0]  rx_first_byte;
    logic [7:0]  rx_second_byte;
    logic [15:0] failsafe_signature;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [2:0]  hop_slot;
    logic        telemetry_take;
    logic [14:0] next_delay_us;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        rx_ready;
    logic        reply_ok;
    logic [15:0] failsafe_signature;
  } cls_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

@@ sv/rclbs_front.sv @@
// ----------------------------------------------------------------------------
// rclbs_front
// Accepts input items and classifies them for the sequencer queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rclbs_front (
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rclbs_pkg::in_item_t in_item,
  input  wire rclbs_pkg::q_stat_t  q_stat,
  output logic                     push,
  output rclbs_pkg::cls_item_t     push_item
);

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_item.cmd                = in_item.cmd;
    push_item.rx_ready           = in_item.rx_ready;
    push_item.reply_ok           = in_item.rx_ready &&
                                   (in_item.rx_first_byte == rclbs_pkg::BYTE_O) &&
                                   (in_item.rx_second_byte == rclbs_pkg::BYTE_K);
    push_item.failsafe_signature = in_item.failsafe_signature;
  end

endmodule

`default_nettype wire

@@ sv/rclbs_queue.sv @@
// ----------------------------------------------------------------------------
// rclbs_queue
// Short register queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rclbs_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rclbs_pkg::q_ctrl_t   q_ctrl,
  input  wire rclbs_pkg::cls_item_t push_item,
  output rclbs_pkg::q_stat_t        q_stat,
  output rclbs_pkg::cls_item_t      head_item
);

  localparam int AW = (rclbs_pkg::QUEUE_DEPTH > 1) ? $clog2(rclbs_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(rclbs_pkg::QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(rclbs_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(rclbs_pkg::QUEUE_DEPTH);

  rclbs_pkg::cls_item_t mem_r [rclbs_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (q_ctrl.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (q_ctrl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({q_ctrl.push, q_ctrl.pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ctrl.push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign q_stat.full  = (count_r == FULL);
  assign q_stat.empty = (count_r == '0);
  assign head_item    = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

@@ sv/rclbs_back.sv @@
// ----------------------------------------------------------------------------
// rclbs_back
// Phase machine: steps bind, data, config and failsafe phases per item.
// ----------------------------------------------------------------------------
`default_nettype none

module rclbs_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rclbs_pkg::q_stat_t   q_stat,
  input  wire rclbs_pkg::cls_item_t head_item,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rclbs_pkg::out_item_t      out_item
);

  localparam logic [2:0] PH_BIND_SEND   = 3'd0;
  localparam logic [2:0] PH_BIND_RX     = 3'd1;
  localparam logic [2:0] PH_BIND_LISTEN = 3'd2;
  localparam logic [2:0] PH_DATA_SEND   = 3'd3;
  localparam logic [2:0] PH_DATA_RX     = 3'd4;
  localparam logic [2:0] PH_RXCFG       = 3'd5;
  localparam logic [2:0] PH_FAILSAFE    = 3'd6;

  localparam logic [3:0] HOP_END   = 4'(rclbs_pkg::HOP_COUNT);
  localparam logic [5:0] RETRY_LIM = 6'(rclbs_pkg::BIND_RETRY_LIMIT);
  localparam logic [5:0] CFG_LIM   = 6'(rclbs_pkg::CONFIG_REPEATS);

  logic [2:0]  phase_r, phase_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [2:0]  hop_r, hop_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] last_sig_r, last_sig_nxt;
  logic        out_valid_r;
  rclbs_pkg::out_item_t out_item_r, res;

  logic [3:0] hop_inc;
  logic [2:0] hop_adv;
  logic [5:0] step_up;

  assign hop_inc = {1'b0, hop_r} + 4'd1;
  assign hop_adv = (hop_inc >= HOP_END) ? 3'd0 : hop_inc[2:0];
  assign step_up = (step_r == 6'd63) ? 6'd63 : step_r + 6'd1;

  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  always_comb begin
    phase_nxt          = phase_r;
    step_nxt           = step_r;
    hop_nxt            = hop_r;
    pending_nxt        = pending_r;
    last_sig_nxt       = last_sig_r;
    res.action         = rclbs_pkg::ACT_IDLE;
    res.telemetry_take = 1'b0;
    res.next_delay_us  = rclbs_pkg::DLY_SHORT;
    unique case (head_item.cmd)
      rclbs_pkg::CMD_START_DATA, rclbs_pkg::CMD_START_BIND: begin
        last_sig_nxt      = '0;
        pending_nxt       = 1'b1;
        res.next_delay_us = rclbs_pkg::DLY_START;
        if (head_item.cmd == rclbs_pkg::CMD_START_DATA) begin
          phase_nxt  = PH_DATA_SEND;
          res.action = rclbs_pkg::ACT_START_DATA;
        end else begin
          phase_nxt  = PH_BIND_SEND;
          res.action = rclbs_pkg::ACT_START_BIND;
        end
      end
      rclbs_pkg::CMD_OPTIONS: begin
        pending_nxt       = 1'b1;
        res.next_delay_us = rclbs_pkg::DLY_NONE;
      end
      default: begin
        unique case (phase_r)
          PH_BIND_SEND: begin
            res.action        = rclbs_pkg::ACT_SEND_BIND;
            phase_nxt         = PH_BIND_RX;
            res.next_delay_us = rclbs_pkg::DLY_SEND;
          end
          PH_BIND_RX: begin
            res.action = rclbs_pkg::ACT_TO_RX;
            phase_nxt  = PH_BIND_LISTEN;
            step_nxt   = '0;
          end
          PH_BIND_LISTEN: begin
            if (head_item.reply_ok) begin
              res.action = rclbs_pkg::ACT_BIND_OK;
              phase_nxt  = PH_DATA_SEND;
            end else begin
              if (step_r >= RETRY_LIM) begin
                phase_nxt = PH_BIND_SEND;
              end
              step_nxt          = step_up;
              res.next_delay_us = rclbs_pkg::DLY_LISTEN;
            end
          end
          PH_DATA_SEND: begin
            res.telemetry_take = head_item.rx_ready;
            if (head_item.failsafe_signature != last_sig_r) begin
              last_sig_nxt = head_item.failsafe_signature;
              step_nxt     = '0;
              phase_nxt    = PH_FAILSAFE;
            end else if (pending_r) begin
              pending_nxt = 1'b0;
              step_nxt    = '0;
              phase_nxt   = PH_RXCFG;
            end else begin
              hop_nxt           = hop_adv;
              res.action        = rclbs_pkg::ACT_SEND_DATA;
              phase_nxt         = PH_DATA_RX;
              res.next_delay_us = rclbs_pkg::DLY_SEND;
            end
          end
          PH_DATA_RX: begin
            res.action        = rclbs_pkg::ACT_TO_RX;
            phase_nxt         = PH_DATA_SEND;
            res.next_delay_us = rclbs_pkg::DLY_DATA;
          end
          PH_RXCFG: begin
            hop_nxt    = hop_adv;
            res.action = rclbs_pkg::ACT_SEND_RXCFG;
            step_nxt   = step_up;
            if (step_up >= CFG_LIM) begin
              phase_nxt = PH_DATA_SEND;
            end
            res.next_delay_us = rclbs_pkg::DLY_CONFIG;
          end
          PH_FAILSAFE: begin
            hop_nxt    = hop_adv;
            res.action = rclbs_pkg::ACT_SEND_FS;
            if (step_r >= CFG_LIM) begin
              phase_nxt = PH_DATA_SEND;
            end
            step_nxt          = step_up;
            res.next_delay_us = rclbs_pkg::DLY_CONFIG;
          end
          default: begin
          end
        endcase
      end
    endcase
    res.hop_slot = hop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BIND_SEND;
      step_r      <= '0;
      hop_r       <= '0;
      pending_r   <= 1'b1;
      last_sig_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r    <= phase_nxt;
        step_r     <= step_nxt;
        hop_r      <= hop_nxt;
        pending_r  <= pending_nxt;
        last_sig_r <= last_sig_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

@@ sv/rc_link_bind_and_data_sequencer.sv @@
// ----------------------------------------------------------------------------
// rc_link_bind_and_data_sequencer
// Radio-link bind and data phase sequencer, one result per input item.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result. The block takes one item per
// clock cycle sustained while the output is not stalled. The accepting edge
// writes the classified item into a two-entry queue; the entry is then popped
// into the phase update, which writes the output register. A stalled output
// fills the queue, after which in_ready drops until results drain. The
// failsafe signature is supplied by the user each tick.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_link_bind_and_data_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rclbs_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rclbs_pkg::out_item_t      out_item
);

  rclbs_pkg::q_ctrl_t   q_ctrl;
  rclbs_pkg::q_stat_t   q_stat;
  rclbs_pkg::cls_item_t push_item;
  rclbs_pkg::cls_item_t head_item;
  logic                 push;
  logic                 pop;

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  rclbs_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  rclbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctrl    (q_ctrl),
    .push_item (push_item),
    .q_stat    (q_stat),
    .head_item (head_item)
  );

  rclbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_item (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ sv/rclbs_checker.sv @@
// ----------------------------------------------------------------------------
// rclbs_checker
// Port-level checks on the sequencer results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rclbs_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire rclbs_pkg::in_item_t  in_item,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire rclbs_pkg::out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_telem_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.telemetry_take |->
      (out_item.action == rclbs_pkg::ACT_IDLE ||
       out_item.action == rclbs_pkg::ACT_SEND_DATA))
    else $error("telemetry flagged outside data listen");

  a_start_delay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.action == rclbs_pkg::ACT_START_BIND ||
                  out_item.action == rclbs_pkg::ACT_START_DATA) |->
      out_item.next_delay_us == rclbs_pkg::DLY_START)
    else $error("start action with wrong delay");

  a_hop_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_item.hop_slot} < 4'(rclbs_pkg::HOP_COUNT)))
    else $error("hop slot out of range");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("accepted item produced no result");

endmodule

bind rc_link_bind_and_data_sequencer rclbs_checker u_rclbs_checker (.*);

`default_nettype wire

@@ sim/tb_rc_link_bind_and_data_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_rc_link_bind_and_data_sequencer
// Drives bind sessions, data sessions and stray commands into the link
// sequencer, predicts each result from a behavioral copy of the phase machine
// and checks every result field in order, with random gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rc_link_bind_and_data_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1350;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int STEADY_FROM  = 800;
  localparam int STEADY_TO    = 1400;

  typedef enum logic [2:0] {
    PH_BIND_SEND   = 3'd0,
    PH_BIND_RX     = 3'd1,
    PH_BIND_LISTEN = 3'd2,
    PH_DATA_SEND   = 3'd3,
    PH_DATA_RX     = 3'd4,
    PH_RXCFG       = 3'd5,
    PH_FAILSAFE    = 3'd6
  } link_phase_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  rclbs_pkg::in_item_t  in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rclbs_pkg::out_item_t out_item;

  rclbs_pkg::in_item_t  pending_items[$];
  rclbs_pkg::out_item_t expected_results[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  logic      steady;

  link_phase_e link_phase   = PH_BIND_SEND;
  logic [5:0]  step_count   = '0;
  logic [2:0]  hop_position = '0;
  logic        cfg_pending  = 1'b1;
  logic [15:0] last_fs_sig  = '0;

  assign steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

  rc_link_bind_and_data_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [2:0] next_hop(input logic [2:0] h);
    int n;
    n = int'(h) + 1;
    return (n >= rclbs_pkg::HOP_COUNT) ? 3'd0 : 3'(n);
  endfunction

  function automatic logic [5:0] sat_inc(input logic [5:0] c);
    return (c == 6'd63) ? 6'd63 : c + 6'd1;
  endfunction

  function automatic rclbs_pkg::out_item_t predict_link_step(input rclbs_pkg::in_item_t it);
    rclbs_pkg::out_item_t r;
    r.action         = rclbs_pkg::ACT_IDLE;
    r.telemetry_take = 1'b0;
    r.next_delay_us  = rclbs_pkg::DLY_SHORT;
    case (it.cmd)
      rclbs_pkg::CMD_START_DATA, rclbs_pkg::CMD_START_BIND: begin
        last_fs_sig     = '0;
        cfg_pending     = 1'b1;
        link_phase      = (it.cmd == rclbs_pkg::CMD_START_DATA) ? PH_DATA_SEND : PH_BIND_SEND;
        r.action        = (it.cmd == rclbs_pkg::CMD_START_DATA) ?
                          rclbs_pkg::ACT_START_DATA : rclbs_pkg::ACT_START_BIND;
        r.next_delay_us = rclbs_pkg::DLY_START;
      end
      rclbs_pkg::CMD_OPTIONS: begin
        cfg_pending     = 1'b1;
        r.next_delay_us = rclbs_pkg::DLY_NONE;
      end
      default: begin
        case (link_phase)
          PH_BIND_SEND: begin
            r.action        = rclbs_pkg::ACT_SEND_BIND;
            link_phase      = PH_BIND_RX;
            r.next_delay_us = rclbs_pkg::DLY_SEND;
          end
          PH_BIND_RX: begin
            r.action   = rclbs_pkg::ACT_TO_RX;
            link_phase = PH_BIND_LISTEN;
            step_count = '0;
          end
          PH_BIND_LISTEN: begin
            if (it.rx_ready && it.rx_first_byte == rclbs_pkg::BYTE_O &&
                it.rx_second_byte == rclbs_pkg::BYTE_K) begin
              r.action   = rclbs_pkg::ACT_BIND_OK;
              link_phase = PH_DATA_SEND;
            end else begin
              if (int'(step_count) >= rclbs_pkg::BIND_RETRY_LIMIT) link_phase = PH_BIND_SEND;
              step_count      = sat_inc(step_count);
              r.next_delay_us = rclbs_pkg::DLY_LISTEN;
            end
          end
          PH_DATA_SEND: begin
            r.telemetry_take = it.rx_ready;
            if (it.failsafe_signature != last_fs_sig) begin
              last_fs_sig = it.failsafe_signature;
              step_count  = '0;
              link_phase  = PH_FAILSAFE;
            end else if (cfg_pending) begin
              cfg_pending = 1'b0;
              step_count  = '0;
              link_phase  = PH_RXCFG;
            end else begin
              hop_position    = next_hop(hop_position);
              r.action        = rclbs_pkg::ACT_SEND_DATA;
              link_phase      = PH_DATA_RX;
              r.next_delay_us = rclbs_pkg::DLY_SEND;
            end
          end
          PH_DATA_RX: begin
            r.action        = rclbs_pkg::ACT_TO_RX;
            link_phase      = PH_DATA_SEND;
            r.next_delay_us = rclbs_pkg::DLY_DATA;
          end
          PH_RXCFG: begin
            hop_position    = next_hop(hop_position);
            r.action        = rclbs_pkg::ACT_SEND_RXCFG;
            step_count      = sat_inc(step_count);
            if (int'(step_count) >= rclbs_pkg::CONFIG_REPEATS) link_phase = PH_DATA_SEND;
            r.next_delay_us = rclbs_pkg::DLY_CONFIG;
          end
          PH_FAILSAFE: begin
            hop_position    = next_hop(hop_position);
            r.action        = rclbs_pkg::ACT_SEND_FS;
            if (int'(step_count) >= rclbs_pkg::CONFIG_REPEATS) link_phase = PH_DATA_SEND;
            step_count      = sat_inc(step_count);
            r.next_delay_us = rclbs_pkg::DLY_CONFIG;
          end
          default: begin
          end
        endcase
      end
    endcase
    r.hop_slot = hop_position;
    return r;
  endfunction

  task automatic add_item(input logic [1:0] cmd, input logic rdy, input logic [7:0] b0,
                          input logic [7:0] b1, input logic [15:0] sig);
    rclbs_pkg::in_item_t it;
    it.cmd                = cmd;
    it.rx_ready           = rdy;
    it.rx_first_byte      = b0;
    it.rx_second_byte     = b1;
    it.failsafe_signature = sig;
    pending_items.push_back(it);
  endtask

  task automatic add_data_ticks(input int count, input logic [15:0] start_sig);
    logic [15:0] sig;
    int          r;
    sig = start_sig;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        add_item(rclbs_pkg::CMD_OPTIONS, 1'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom));
      end else begin
        if (r < 9) sig = 16'($urandom);
        add_item(rclbs_pkg::CMD_TICK, 1'($urandom), 8'($urandom), 8'($urandom), sig);
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_rc_link_bind_and_data_sequencer: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_link_step(in_item));
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rclbs_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %h", out_item));
        end else begin
          want = expected_results.pop_front();
          if (out_item.action !== want.action)
            report_mismatch($sformatf("action %0d, want %0d", out_item.action, want.action));
          if (out_item.hop_slot !== want.hop_slot)
            report_mismatch($sformatf("hop_slot %0d, want %0d",
                                      out_item.hop_slot, want.hop_slot));
          if (out_item.telemetry_take !== want.telemetry_take)
            report_mismatch($sformatf("telemetry_take %b, want %b",
                                      out_item.telemetry_take, want.telemetry_take));
          if (out_item.next_delay_us !== want.next_delay_us)
            report_mismatch($sformatf("next_delay_us %0d, want %0d",
                                      out_item.next_delay_us, want.next_delay_us));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  initial begin
    int          kind;
    int          misses;
    logic [15:0] sig;

    add_item(rclbs_pkg::CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000);
    add_item(rclbs_pkg::CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000);
    add_item(rclbs_pkg::CMD_TICK, 1'b0, rclbs_pkg::BYTE_O, rclbs_pkg::BYTE_K, 16'h0000);
    add_item(rclbs_pkg::CMD_TICK, 1'b1, rclbs_pkg::BYTE_O, 8'hFF, 16'hFFFF);
    add_item(rclbs_pkg::CMD_TICK, 1'b1, 8'hFF, rclbs_pkg::BYTE_K, 16'h0000);
    add_item(rclbs_pkg::CMD_TICK, 1'b1, rclbs_pkg::BYTE_O, rclbs_pkg::BYTE_K, 16'h0000);
    add_item(rclbs_pkg::CMD_TICK, 1'b1, 8'hFF, 8'hFF, 16'h0000);
    add_item(rclbs_pkg::CMD_OPTIONS, 1'b1, 8'hFF, 8'hFF, 16'hFFFF);
    add_item(rclbs_pkg::CMD_TICK, 1'b0, 8'h00, 8'h00, 16'hFFFF);
    add_item(rclbs_pkg::CMD_TICK, 1'b1, 8'hFF, 8'hFF, 16'hFFFF);
    add_item(rclbs_pkg::CMD_START_DATA, 1'b1, 8'hFF, 8'hFF, 16'hFFFF);
    add_item(rclbs_pkg::CMD_TICK, 1'b1, 8'h00, 8'h00, 16'h0000);
    add_item(rclbs_pkg::CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000);
    add_item(rclbs_pkg::CMD_START_BIND, 1'b0, 8'h00, 8'h00, 16'h0000);
    add_item(rclbs_pkg::CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000);

    while (pending_items.size() < ITEM_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        add_item(rclbs_pkg::CMD_START_BIND, 1'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom));
        add_item(rclbs_pkg::CMD_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom));
        add_item(rclbs_pkg::CMD_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                 16'($urandom));
        misses = ($urandom_range(7) == 0) ? $urandom_range(51, 60) : $urandom_range(0, 12);
        for (int i = 0; i < misses; i++) begin
          case ($urandom_range(2))
            0: add_item(rclbs_pkg::CMD_TICK, 1'b0, rclbs_pkg::BYTE_O, rclbs_pkg::BYTE_K,
                        16'($urandom));
            1: add_item(rclbs_pkg::CMD_TICK, 1'b1, rclbs_pkg::BYTE_O, 8'($urandom),
                        16'($urandom));
            default: add_item(rclbs_pkg::CMD_TICK, 1'($urandom), 8'($urandom), 8'($urandom),
                              16'($urandom));
          endcase
        end
        add_item(rclbs_pkg::CMD_TICK, 1'b1, rclbs_pkg::BYTE_O, rclbs_pkg::BYTE_K,
                 16'($urandom));
        if ($urandom_range(1) == 1) add_data_ticks($urandom_range(10, 50), 16'($urandom));
      end else if (kind < 80) begin
        sig = ($urandom_range(5) == 0) ? 16'h0000 : 16'($urandom);
        if ($urandom_range(9) < 7)
          add_item(rclbs_pkg::CMD_START_DATA, 1'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom));
        add_data_ticks($urandom_range(20, 70), sig);
      end else begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          add_item(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      end
    end

    while (!rst_n) @(posedge clk);
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_rc_link_bind_and_data_sequencer: PASS");
    end else begin
      $display("tb_rc_link_bind_and_data_sequencer: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
